@@ rtl/nfcrx_pkg.sv @@
// Package for the NFC frame receiver/checker.
// Constants, status codes and defaults; no dependencies.
package nfcrx_pkg;

    localparam int unsigned MAX_FRAME_DATA_DEF = 32;
    localparam logic [7:0]  EXP_LEN_RST        = 8'd34;
    localparam logic [8:0]  ZERO_BUDGET_PAD    = 9'd8;

    localparam logic [7:0]  BYTE_ZERO = 8'h00;
    localparam logic [7:0]  BYTE_SOF  = 8'hFF;

    typedef logic [2:0] t_status;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_BAD_START = 3'd1;
    localparam t_status ST_LCS_ERR   = 3'd2;
    localparam t_status ST_DCS_ERR   = 3'd3;
    localparam t_status ST_TOO_LONG  = 3'd4;

endpackage

@@ rtl/nfcrx_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nfcrx_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/nfc_frame_receiver_checker_core.sv @@
// Top level of the NFC normal information frame receiver/checker.
// Depends on nfcrx_pkg and nfcrx_ram.
//
// Received bytes are taken one per cycle while hunting for the start code and
// collecting LEN, LCS, data and DCS; each input beat is taken only when the
// output register is free (or being emptied in the same cycle). Data bytes go
// into a MAX_FRAME_DATA-deep RAM. After a good DCS the frame is drained from
// the RAM read port, each beat a RAM read and then an output register load;
// no new read starts until the previous byte is loaded. Input is held off for
// the whole drain. Errors and the empty frame give a single beat.
// The RAM needs no clearing: only entries written in the current frame are read.
module nfc_frame_receiver_checker_core #(
    parameter int unsigned MAX_FRAME_DATA = nfcrx_pkg::MAX_FRAME_DATA_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,   // expected_length
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // [7:0] data_byte, [15:8] frame_length
    output logic [3:0]  m_axis_tuser,    // [0] data_valid, [3:1] status
    output logic        m_axis_tlast     // is_last
);

    import nfcrx_pkg::*;

    localparam int unsigned AW = (MAX_FRAME_DATA > 1) ? $clog2(MAX_FRAME_DATA) : 1;
    localparam int unsigned CW = $clog2(MAX_FRAME_DATA + 1);
    localparam logic [7:0]  MAX_LEN = 8'(MAX_FRAME_DATA);

    typedef enum logic [5:0] {
        PH_HUNT  = 6'b000001,
        PH_LEN   = 6'b000010,
        PH_LCS   = 6'b000100,
        PH_DATA  = 6'b001000,
        PH_DCS   = 6'b010000,
        PH_DRAIN = 6'b100000
    } t_phase;

    t_phase        r_phase,     n_phase;
    logic [7:0]    r_exp_len;
    logic [8:0]    r_zero_cnt,  n_zero_cnt;
    logic [7:0]    r_len,       n_len;
    logic [CW-1:0] r_data_cnt,  n_data_cnt;
    logic [7:0]    r_sum,       n_sum;
    logic [AW-1:0] r_drain_idx, n_drain_idx;
    logic          r_rd_pend,   n_rd_pend;
    logic          r_pend_last, n_pend_last;

    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_data,  n_out_data;
    logic          r_out_dv,    n_out_dv;
    logic          r_out_last,  n_out_last;
    t_status       r_out_st,    n_out_st;
    logic [7:0]    r_out_flen,  n_out_flen;

    logic          in_acc;
    logic          out_acc;
    logic [8:0]    budget;
    logic [8:0]    zc_inc;
    logic          drain_last;
    logic          ram_we;
    logic [7:0]    ram_rdata;

    assign in_acc     = s_axis_tvalid && s_axis_tready;
    assign out_acc    = m_axis_tvalid && m_axis_tready;
    assign budget     = {1'b0, r_exp_len} + ZERO_BUDGET_PAD;
    assign zc_inc     = r_zero_cnt + 9'd1;
    assign drain_last = (8'(r_drain_idx) + 8'd1) == r_len;

    assign s_axis_tready = (r_phase != PH_DRAIN) && !r_rd_pend
                        && (!r_out_valid || m_axis_tready);

    nfcrx_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME_DATA)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_data_cnt[AW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_raddr (r_drain_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_phase     = r_phase;
        n_zero_cnt  = r_zero_cnt;
        n_len       = r_len;
        n_data_cnt  = r_data_cnt;
        n_sum       = r_sum;
        n_drain_idx = r_drain_idx;
        n_rd_pend   = 1'b0;
        n_pend_last = r_pend_last;
        n_out_valid = r_out_valid && !out_acc;
        n_out_data  = r_out_data;
        n_out_dv    = r_out_dv;
        n_out_last  = r_out_last;
        n_out_st    = r_out_st;
        n_out_flen  = r_out_flen;
        ram_we      = 1'b0;

        if (r_rd_pend) begin
            n_out_valid = 1'b1;
            n_out_data  = ram_rdata;
            n_out_dv    = 1'b1;
            n_out_last  = r_pend_last;
            n_out_st    = ST_OK;
            n_out_flen  = r_len;
        end

        case (r_phase)
            PH_HUNT: begin
                if (in_acc) begin
                    if ((s_axis_tdata == BYTE_ZERO) && (zc_inc < budget)) begin
                        n_zero_cnt = zc_inc;
                    end else if ((s_axis_tdata == BYTE_SOF) && (zc_inc < budget)) begin
                        n_zero_cnt = '0;
                        n_phase    = PH_LEN;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_data  = '0;
                        n_out_dv    = 1'b0;
                        n_out_last  = 1'b1;
                        n_out_st    = ST_BAD_START;
                        n_out_flen  = '0;
                        n_zero_cnt  = '0;
                    end
                end
            end
            PH_LEN: begin
                if (in_acc) begin
                    n_len   = s_axis_tdata;
                    n_phase = PH_LCS;
                end
            end
            PH_LCS: begin
                if (in_acc) begin
                    n_data_cnt = '0;
                    n_sum      = '0;
                    if ((r_len + s_axis_tdata) != 8'd0 || r_len > MAX_LEN) begin
                        n_out_valid = 1'b1;
                        n_out_data  = '0;
                        n_out_dv    = 1'b0;
                        n_out_last  = 1'b1;
                        n_out_st    = ((r_len + s_axis_tdata) != 8'd0) ? ST_LCS_ERR
                                                                        : ST_TOO_LONG;
                        n_out_flen  = r_len;
                        n_zero_cnt  = '0;
                        n_phase     = PH_HUNT;
                    end else begin
                        n_phase = (r_len == 8'd0) ? PH_DCS : PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                if (in_acc) begin
                    ram_we     = 1'b1;
                    n_sum      = r_sum + s_axis_tdata;
                    n_data_cnt = r_data_cnt + CW'(1);
                    if ((8'(r_data_cnt) + 8'd1) == r_len) begin
                        n_phase = PH_DCS;
                    end
                end
            end
            PH_DCS: begin
                if (in_acc) begin
                    n_zero_cnt  = '0;
                    n_data_cnt  = '0;
                    n_sum       = '0;
                    n_drain_idx = '0;
                    if ((r_sum + s_axis_tdata) != 8'd0) begin
                        n_out_valid = 1'b1;
                        n_out_data  = '0;
                        n_out_dv    = 1'b0;
                        n_out_last  = 1'b1;
                        n_out_st    = ST_DCS_ERR;
                        n_out_flen  = r_len;
                        n_phase     = PH_HUNT;
                    end else if (r_len == 8'd0) begin
                        n_out_valid = 1'b1;
                        n_out_data  = '0;
                        n_out_dv    = 1'b0;
                        n_out_last  = 1'b1;
                        n_out_st    = ST_OK;
                        n_out_flen  = '0;
                        n_phase     = PH_HUNT;
                    end else begin
                        n_phase = PH_DRAIN;
                    end
                end
            end
            PH_DRAIN: begin
                if (!r_rd_pend && (!r_out_valid || out_acc)) begin
                    n_rd_pend   = 1'b1;
                    n_pend_last = drain_last;
                    if (drain_last) begin
                        n_drain_idx = '0;
                        n_phase     = PH_HUNT;
                    end else begin
                        n_drain_idx = r_drain_idx + AW'(1);
                    end
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_exp_len   <= EXP_LEN_RST;
            r_zero_cnt  <= '0;
            r_len       <= '0;
            r_data_cnt  <= '0;
            r_sum       <= '0;
            r_drain_idx <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            if (i_cfg_wr_en) begin
                r_exp_len <= i_cfg_wr_data;
            end
            r_zero_cnt  <= n_zero_cnt;
            r_len       <= n_len;
            r_data_cnt  <= n_data_cnt;
            r_sum       <= n_sum;
            r_drain_idx <= n_drain_idx;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_last <= n_pend_last;
        r_out_data  <= n_out_data;
        r_out_dv    <= n_out_dv;
        r_out_last  <= n_out_last;
        r_out_st    <= n_out_st;
        r_out_flen  <= n_out_flen;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_flen, r_out_data};
    assign m_axis_tuser  = {r_out_st, r_out_dv};
    assign m_axis_tlast  = r_out_last;

endmodule

@@ rtl/nfcrx_chk.sv @@
// Port-level checker for the NFC frame receiver/checker, with its bind.
// Depends on nfcrx_pkg and nfc_frame_receiver_checker_core.
module nfcrx_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    import nfcrx_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[3:1] != ST_OK) |-> m_axis_tlast && !m_axis_tuser[0]
            && (m_axis_tdata[7:0] == 8'd0))
        else $error("error beat not a lone last beat");

    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tuser[3:1] == ST_OK)
            && (m_axis_tdata[15:8] != 8'd0))
        else $error("data beat with bad status or zero length");

    a_in_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready && m_axis_tvalid |-> m_axis_tready)
        else $error("input taken while output register blocked");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind nfc_frame_receiver_checker_core nfcrx_chk u_nfcrx_chk (.*);
